>>> sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants
// Fixed-point constants, the arctangent table and the sideband struct used
// by the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QUAT_W    = 16;
  localparam int SUM_W     = 34;  // exact products sums, signed
  localparam int ATN_IN_W  = 36;  // atan2 operand width, signed
  localparam int XY_W      = 62;  // CORDIC vector width, signed
  localparam int Z_W       = 52;  // Q48 angle accumulator, signed
  localparam int ANG_Q     = 48;
  localparam int CORDIC_STEPS = 48;
  localparam int SQRT_STEPS   = 32;
  localparam int ROOT_W    = 32;
  localparam int ABSP_W    = 27;
  localparam int PSQ_W     = 54;
  localparam int ANGLE_W   = 16;
  localparam int NORM_MSB  = 57;  // normalised magnitude lies in [2^57, 2^58)
  localparam int SHIFT_W   = 6;

  localparam longint QUAT_SCALE_SQ = 64'd100000000;
  localparam longint SCALE_SQ_SQ   = 64'd10000000000000000;

  // Special results decided before the CORDIC chain
  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_PI,
    SP_PHALF,
    SP_NHALF
  } qte_spec_t;

  // Operands carried alongside the square-root pipeline
  typedef struct packed {
    logic signed [SUM_W-1:0]    roll_y;
    logic signed [SUM_W-1:0]    roll_x;
    logic signed [SUM_W-1:0]    yaw_y;
    logic signed [SUM_W-1:0]    yaw_x;
    logic signed [ATN_IN_W-1:0] pitch_y;
    logic                       clamp;
    logic                       neg;
  } qte_side_t;

  // restoring long division, only ever run while building constants
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 by alternating series, i >= 1
  function automatic longint atan_pow2_q60(input int i);
    longint unsigned t;
    longint unsigned d;
    longint unsigned q;
    longint          sum;
    bit              neg;
    t = 64'h1000_0000_0000_0000 >> i;
    d = 1;
    sum = 0;
    neg = 1'b0;
    while (t != 0) begin
      q = udiv64(t, d);
      sum = neg ? sum - longint'(q) : sum + longint'(q);
      neg = !neg;
      d = d + 2;
      t = t >> (2 * i);
    end
    return sum;
  endfunction

  // atan(1/3) in Q60
  function automatic longint atan_third_q60();
    longint unsigned t;
    longint unsigned d;
    longint unsigned q;
    longint          sum;
    bit              neg;
    t = udiv64(64'h1000_0000_0000_0000, 64'd3);
    d = 1;
    sum = 0;
    neg = 1'b0;
    while (t != 0) begin
      q = udiv64(t, d);
      sum = neg ? sum - longint'(q) : sum + longint'(q);
      neg = !neg;
      d = d + 2;
      t = udiv64(t, 64'd9);
    end
    return sum;
  endfunction

  function automatic logic [ANG_Q-1:0] atan_q48(input int i);
    longint v;
    if (i == 0) begin
      v = atan_pow2_q60(1) + atan_third_q60();
    end else begin
      v = atan_pow2_q60(i);
    end
    return ANG_Q'((v + 2048) >>> 12);
  endfunction

  function automatic logic [Z_W-1:0] half_pi_q48();
    longint v;
    v = atan_pow2_q60(1) + atan_third_q60();
    return Z_W'((2 * v + 2048) >>> 12);
  endfunction

  localparam logic [Z_W-1:0] HALF_PI_Q48 = half_pi_q48();

endpackage

>>> sv/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front: quaternion products and sums
// Four stages: products, exact sums and pitch limit check, pitch square,
// radicand for the pitch cosine.
// ----------------------------------------------------------------------------
module qte_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_w,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_x,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_y,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_z,
  output logic                              out_valid,
  output logic [63:0]                       out_rem,
  output qte_pkg::qte_side_t                out_side
);

  localparam logic signed [qte_pkg::SUM_W-1:0] SCALE_S =
    qte_pkg::SUM_W'(qte_pkg::QUAT_SCALE_SQ);

  // stage 1: products
  logic               v1_r;
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r;
  logic signed [31:0] p_wy_r, p_zx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= quat_w * quat_x;
      p_yz_r <= quat_y * quat_z;
      p_xx_r <= quat_x * quat_x;
      p_yy_r <= quat_y * quat_y;
      p_wz_r <= quat_w * quat_z;
      p_xy_r <= quat_x * quat_y;
      p_zz_r <= quat_z * quat_z;
      p_wy_r <= quat_w * quat_y;
      p_zx_r <= quat_z * quat_x;
    end
  end

  // stage 2: exact sums
  logic signed [32:0] s_roll_y, s_roll_x, s_yaw_y, s_yaw_x, s_p;
  logic signed [qte_pkg::SUM_W-1:0] pn;
  logic                             clamp_nxt;
  logic [qte_pkg::SUM_W-1:0]        pn_mag;
  qte_pkg::qte_side_t               side_nxt;
  logic [qte_pkg::ABSP_W-1:0]       absp_nxt;

  always_comb begin
    s_roll_y = 33'(p_wx_r) + 33'(p_yz_r);
    s_roll_x = 33'(p_xx_r) + 33'(p_yy_r);
    s_yaw_y  = 33'(p_wz_r) + 33'(p_xy_r);
    s_yaw_x  = 33'(p_yy_r) + 33'(p_zz_r);
    s_p      = 33'(p_wy_r) - 33'(p_zx_r);
    pn       = {s_p, 1'b0};
    clamp_nxt = (pn >= SCALE_S) || (pn <= -SCALE_S);
    pn_mag   = pn[qte_pkg::SUM_W-1] ? qte_pkg::SUM_W'(-pn) : qte_pkg::SUM_W'(pn);
    absp_nxt = clamp_nxt ? '0 : pn_mag[qte_pkg::ABSP_W-1:0];
    side_nxt.roll_y  = {s_roll_y, 1'b0};
    side_nxt.roll_x  = SCALE_S - qte_pkg::SUM_W'({s_roll_x, 1'b0});
    side_nxt.yaw_y   = {s_yaw_y, 1'b0};
    side_nxt.yaw_x   = SCALE_S - qte_pkg::SUM_W'({s_yaw_x, 1'b0});
    side_nxt.pitch_y = clamp_nxt ? '0 : {pn[31:0], 4'b0000};
    side_nxt.clamp   = clamp_nxt;
    side_nxt.neg     = pn[qte_pkg::SUM_W-1];
  end

  logic                         v2_r;
  qte_pkg::qte_side_t           side2_r;
  logic [qte_pkg::ABSP_W-1:0]   absp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side_nxt;
      absp_r  <= absp_nxt;
    end
  end

  // stage 3: square of the pitch sum
  logic                        v3_r;
  qte_pkg::qte_side_t          side3_r;
  logic [qte_pkg::PSQ_W-1:0]   psq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side2_r;
      psq_r   <= absp_r * absp_r;
    end
  end

  // stage 4: radicand (S*S - P*P) * 256
  logic               v4_r;
  qte_pkg::qte_side_t side4_r;
  logic [63:0]        rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      rem_r   <= (64'(qte_pkg::SCALE_SQ_SQ) - 64'(psq_r)) << 8;
    end
  end

  assign out_valid = v4_r;
  assign out_rem   = rem_r;
  assign out_side  = side4_r;

endmodule

>>> sv/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// One result bit per stage, floor root of a 64-bit radicand; sideband
// operands travel alongside.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [63:0]                       in_rem,
  input  qte_pkg::qte_side_t                in_side,
  output logic                              out_valid,
  output logic [qte_pkg::ROOT_W-1:0]        out_root,
  output qte_pkg::qte_side_t                out_side
);

  localparam int N = qte_pkg::SQRT_STEPS;

  logic               v_s    [0:N];
  logic [63:0]        rem_s  [0:N];
  logic [63:0]        root_s [0:N];
  qte_pkg::qte_side_t side_s [0:N];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = in_rem;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [63:0] BIT_W = 64'(1) << (62 - 2 * i);
    logic [63:0] trial;
    logic [63:0] rem_nxt, root_nxt;

    always_comb begin
      trial = root_s[i] + BIT_W;
      if (rem_s[i] >= trial) begin
        rem_nxt  = rem_s[i] - trial;
        root_nxt = (root_s[i] >> 1) + BIT_W;
      end else begin
        rem_nxt  = rem_s[i];
        root_nxt = root_s[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= rem_nxt;
        root_s[i+1] <= root_nxt;
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = v_s[N];
  assign out_root  = root_s[N][qte_pkg::ROOT_W-1:0];
  assign out_side  = side_s[N];

endmodule

>>> sv/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2: pipelined vectoring CORDIC arctangent
// Special case decode, normalising shift over two stages, half-plane turn,
// 48 micro-rotations and a rounding stage.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int FRAC_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [qte_pkg::ATN_IN_W-1:0] in_y,
  input  logic signed [qte_pkg::ATN_IN_W-1:0] in_x,
  input  logic                                in_clamp,
  input  logic                                in_clamp_neg,
  output logic                                out_valid,
  output logic signed [qte_pkg::ANGLE_W-1:0]  out_angle,
  output logic                                out_clamp
);

  localparam int IW  = qte_pkg::ATN_IN_W;
  localparam int XW  = qte_pkg::XY_W;
  localparam int ZW  = qte_pkg::Z_W;
  localparam int SW  = qte_pkg::SHIFT_W;
  localparam int N   = qte_pkg::CORDIC_STEPS;
  localparam int RND_SH = qte_pkg::ANG_Q - FRAC_BITS;
  localparam logic [ZW-1:0] RND_HALF = ZW'(1) << (RND_SH - 1);
  localparam logic signed [ZW-1:0] HALF_PI = qte_pkg::HALF_PI_Q48;

  // A1: special cases and magnitudes
  logic [IW-1:0]       ax, ay;
  qte_pkg::qte_spec_t  code_nxt;

  always_comb begin
    ax = in_x[IW-1] ? IW'(-in_x) : IW'(in_x);
    ay = in_y[IW-1] ? IW'(-in_y) : IW'(in_y);
    if (in_clamp) begin
      code_nxt = in_clamp_neg ? qte_pkg::SP_NHALF : qte_pkg::SP_PHALF;
    end else if (in_y == '0) begin
      code_nxt = in_x[IW-1] ? qte_pkg::SP_PI : qte_pkg::SP_ZERO;
    end else begin
      code_nxt = qte_pkg::SP_NONE;
    end
  end

  logic                   v1_r;
  logic signed [IW-1:0]   x1_r, y1_r;
  logic [IW-1:0]          m1_r;
  qte_pkg::qte_spec_t     code1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_x;
      y1_r    <= in_y;
      m1_r    <= (ax > ay) ? ax : ay;
      code1_r <= code_nxt;
    end
  end

  // A2: shift amount from leading one
  logic [SW-1:0] msb;

  always_comb begin
    msb = '0;
    for (int b = 0; b < IW; b++) begin
      if (m1_r[b]) begin
        msb = SW'(b);
      end
    end
  end

  logic                 v2_r;
  logic signed [IW-1:0] x2_r, y2_r;
  logic [SW-1:0]        k2_r;
  qte_pkg::qte_spec_t   code2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      k2_r    <= SW'(7'(qte_pkg::NORM_MSB) - 7'(msb));
      code2_r <= code1_r;
    end
  end

  // A3: normalising shift
  logic                 v3_r;
  logic signed [XW-1:0] x3_r, y3_r;
  qte_pkg::qte_spec_t   code3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r    <= XW'(x2_r) <<< k2_r;
      y3_r    <= XW'(y2_r) <<< k2_r;
      code3_r <= code2_r;
    end
  end

  // A4: turn into the right half plane
  logic signed [XW-1:0] x4_nxt, y4_nxt;
  logic signed [ZW-1:0] z4_nxt;

  always_comb begin
    x4_nxt = x3_r;
    y4_nxt = y3_r;
    z4_nxt = '0;
    if (x3_r[XW-1]) begin
      if (!y3_r[XW-1]) begin
        x4_nxt = y3_r;
        y4_nxt = -x3_r;
        z4_nxt = HALF_PI;
      end else begin
        x4_nxt = -y3_r;
        y4_nxt = x3_r;
        z4_nxt = -HALF_PI;
      end
    end
  end

  logic                 v_s    [0:N];
  logic signed [XW-1:0] x_s    [0:N];
  logic signed [XW-1:0] y_s    [0:N];
  logic signed [ZW-1:0] z_s    [0:N];
  qte_pkg::qte_spec_t   code_s [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]    <= x4_nxt;
      y_s[0]    <= y4_nxt;
      z_s[0]    <= z4_nxt;
      code_s[0] <= code3_r;
    end
  end

  // micro-rotations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(qte_pkg::atan_q48(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        code_s[i+1] <= code_s[i];
        if (y_s[i] > 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + ANG;
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - ANG;
        end
      end
    end
  end

  // final: special override and round half away from zero
  logic signed [ZW-1:0] zsel;
  logic [ZW-1:0]        zmag, zrnd;
  logic signed [ZW-1:0] zres;

  always_comb begin
    case (code_s[N])
      qte_pkg::SP_ZERO:  zsel = '0;
      qte_pkg::SP_PI:    zsel = HALF_PI <<< 1;
      qte_pkg::SP_PHALF: zsel = HALF_PI;
      qte_pkg::SP_NHALF: zsel = -HALF_PI;
      default:           zsel = z_s[N];
    endcase
    zmag = zsel[ZW-1] ? ZW'(-zsel) : ZW'(zsel);
    zrnd = (zmag + RND_HALF) >> RND_SH;
    zres = zsel[ZW-1] ? -$signed(zrnd) : $signed(zrnd);
  end

  logic                                vf_r;
  logic signed [qte_pkg::ANGLE_W-1:0]  angle_r;
  logic                                clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_s[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zres[qte_pkg::ANGLE_W-1:0];
      clamp_r <= (code_s[N] == qte_pkg::SP_PHALF) || (code_s[N] == qte_pkg::SP_NHALF);
    end
  end

  assign out_valid = vf_r;
  assign out_angle = angle_r;
  assign out_clamp = clamp_r;

endmodule

>>> sv/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler: orientation quaternion to roll, pitch and yaw
// Exact integer sums feed three pipelined CORDIC arctangent units; pitch
// takes its cosine term from a pipelined square root.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_quat_w/x/y/z            | sink
//  out     | out_valid, out_stall, out_roll_angle,          | source
//          | out_pitch_angle, out_yaw_angle, out_pitch_clamped |
//
//  One transfer accepted per clock while in_stall is low; 4 product/sum
//  stages, 32 square-root stages, 53 arctangent stages: decode, two for the
//  normalising shift, half-plane turn, 48 rotations, rounding.
//  A one-entry skid register behind the pipeline takes the result shown
//  when out_stall rises; in_stall is that register's full flag, so a stall
//  freezes every stage and nothing is lost or repeated.
//  Synchronous active-low reset clears the valid bits and the skid flag.
//
module quaternion_to_euler #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_w,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_x,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_y,
  input  logic signed [qte_pkg::QUAT_W-1:0]  in_quat_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_roll_angle,
  output logic signed [14:0]                 out_pitch_angle,
  output logic signed [15:0]                 out_yaw_angle,
  output logic                               out_pitch_clamped
);

  localparam int IW = qte_pkg::ATN_IN_W;

  logic skid_valid_r, skid_valid_nxt;
  logic en;

  // whole pipeline moves while the skid register is empty
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // products, sums, radicand
  logic               fr_valid;
  logic [63:0]        fr_rem;
  qte_pkg::qte_side_t fr_side;

  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .quat_w    (in_quat_w),
    .quat_x    (in_quat_x),
    .quat_y    (in_quat_y),
    .quat_z    (in_quat_z),
    .out_valid (fr_valid),
    .out_rem   (fr_rem),
    .out_side  (fr_side)
  );

  // pitch cosine term, other operands ride along
  logic                          sq_valid;
  logic [qte_pkg::ROOT_W-1:0]    sq_root;
  qte_pkg::qte_side_t            sq_side;

  qte_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rem    (fr_rem),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // three arctangent units in lockstep
  logic                v_roll, v_pitch, v_yaw;
  logic signed [15:0]  a_roll, a_pitch, a_yaw;
  logic                c_roll, c_pitch, c_yaw;

  qte_atan2 #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sq_valid),
    .in_y         (IW'(sq_side.roll_y)),
    .in_x         (IW'(sq_side.roll_x)),
    .in_clamp     (1'b0),
    .in_clamp_neg (1'b0),
    .out_valid    (v_roll),
    .out_angle    (a_roll),
    .out_clamp    (c_roll)
  );

  qte_atan2 #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sq_valid),
    .in_y         (sq_side.pitch_y),
    .in_x         ($signed(IW'(sq_root))),
    .in_clamp     (sq_side.clamp),
    .in_clamp_neg (sq_side.neg),
    .out_valid    (v_pitch),
    .out_angle    (a_pitch),
    .out_clamp    (c_pitch)
  );

  qte_atan2 #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sq_valid),
    .in_y         (IW'(sq_side.yaw_y)),
    .in_x         (IW'(sq_side.yaw_x)),
    .in_clamp     (1'b0),
    .in_clamp_neg (1'b0),
    .out_valid    (v_yaw),
    .out_angle    (a_yaw),
    .out_clamp    (c_yaw)
  );

  // units run in lockstep, so their valids agree; roll and yaw never clamp
  logic v_last, c_last;
  assign v_last = v_roll & v_pitch & v_yaw;
  assign c_last = c_roll | c_pitch | c_yaw;

  // skid register
  logic signed [15:0] skid_roll_r, skid_yaw_r;
  logic signed [14:0] skid_pitch_r;
  logic               skid_clamp_r;

  always_comb begin
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (v_last && out_stall) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r && v_last && out_stall) begin
      skid_roll_r  <= a_roll;
      skid_pitch_r <= a_pitch[14:0];
      skid_yaw_r   <= a_yaw;
      skid_clamp_r <= c_last;
    end
  end

  assign out_valid         = skid_valid_r | v_last;
  assign out_roll_angle    = skid_valid_r ? skid_roll_r  : a_roll;
  assign out_pitch_angle   = skid_valid_r ? skid_pitch_r : a_pitch[14:0];
  assign out_yaw_angle     = skid_valid_r ? skid_yaw_r   : a_yaw;
  assign out_pitch_clamped = skid_valid_r ? skid_clamp_r : c_last;

endmodule
